/* rtl/clt_pkg.sv */
// clt_pkg: shared types and constants for the compacting list table
// command and status codes, sequencer states, shared adder operations
// no dependencies
package clt_pkg;

    localparam int DATA_W = 32;
    localparam int MEAN_W = 40;
    localparam int FRAC_W = 8;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_AVG    = 2'd2;
    localparam logic [1:0] ACT_REMOVE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ISSUE,
        S_CHECK,
        S_FILL,
        S_ABS,
        S_DIV,
        S_NEG,
        S_OUT
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

/* rtl/clt_ram.sv */
// clt_ram: generic single write port, single read port memory
// read data is registered; no dependencies
module clt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 10
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/clt_alu.sv */
// clt_alu: the one shared adder/subtractor of the sequencer
// depends on clt_pkg for the operation codes
module clt_alu
    import clt_pkg::*;
#(
    parameter int WIDTH = 47
) (
    input  alu_op_t          op,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH-1:0] res
);

    always_comb
    begin
        case (op)
            ALU_ADD: res = a + b;
            ALU_SUB: res = a - b;
            default: res = a + b;
        endcase
    end

endmodule

/* rtl/compacting_list_table_unit.sv */
// compacting_list_table_unit: top level of the packed signed list table
// depends on clt_pkg, clt_ram and clt_alu
//
// usage
// - cmd channel (cmd_valid/cmd_ready) carries action and operand_value;
//   a transfer happens when both are high, cmd_ready is high only while idle
// - rsp channel (rsp_valid/rsp_ready) carries entry_value, mean_q8, status
//   and last; the result sits in an output register, so the next command is
//   taken while the last result still waits for the receiver
// - add and remove give one result, read gives SLOT_COUNT results in slot
//   order with last on the final one, average gives one result
// - sequencing: the sequencer reads each slot through the registered
//   memory port, in an issue state and then a check state; average adds
//   a restoring division, one quotient bit per cycle on the shared adder
// - a stalled receiver holds the sequencer on a read until each transfer
// - reset clears the valid bits, so every slot reads as empty at once;
//   no clearing pass is needed
module compacting_list_table_unit
    import clt_pkg::*;
#(
    parameter int SLOT_COUNT = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  logic [1:0]               action,
    input  logic signed [DATA_W-1:0] operand_value,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output logic signed [DATA_W-1:0] entry_value,
    output logic signed [MEAN_W-1:0] mean_q8,
    output logic [1:0]               status,
    output logic                     last
);

    // widths derived from the slot count
    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int ACC_W  = DATA_W + CNT_W + FRAC_W;   // sum, then dividend/quotient
    localparam int STEP_W = $clog2(ACC_W);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SLOT_COUNT - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ACC_W - 1);

    // sequencer and command registers
    state_t              state_reg, state_next;
    logic [1:0]          act_reg, act_next;
    logic [DATA_W-1:0]   opnd_reg, opnd_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    wr_reg, wr_next;      // compaction write pointer
    logic [CNT_W-1:0]    cnt_reg, cnt_next;    // nonzero slots seen
    logic [ACC_W-1:0]    acc_reg, acc_next;    // running sum, then quotient
    logic [CNT_W-1:0]    rem_reg, rem_next;    // division remainder
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                neg_reg, neg_next;
    logic                rvld_reg, rvld_next;  // valid bit of the slot in flight
    logic [MEAN_W-1:0]   mean_res_reg, mean_res_next;
    logic [1:0]          stat_res_reg, stat_res_next;

    // slot valid bits: a slot never written reads as zero
    logic [SLOT_COUNT-1:0] vld_reg, vld_next;

    // output register
    logic                ov_reg, ov_next;
    logic [DATA_W-1:0]   oent_reg, oent_next;
    logic [MEAN_W-1:0]   omean_reg, omean_next;
    logic [1:0]          ostat_reg, ostat_next;
    logic                olast_reg, olast_next;

    // memory port
    logic                ram_we, ram_re;
    logic [IDX_W-1:0]    ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [DATA_W-1:0]   ram_rdata;

    // shared adder
    alu_op_t             alu_op;
    logic [ACC_W-1:0]    alu_a, alu_b, alu_res;

    logic                out_free;
    logic [DATA_W-1:0]   slot_val;
    logic [CNT_W:0]      rem_sh;

    clt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    clt_alu #(
        .WIDTH (ACC_W)
    ) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    assign out_free = !ov_reg || rsp_ready;
    assign slot_val = rvld_reg ? ram_rdata : '0;
    // next partial remainder: shift in the top dividend bit
    assign rem_sh   = {rem_reg, acc_reg[ACC_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vld_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
            ov_reg    <= ov_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        opnd_reg     <= opnd_next;
        idx_reg      <= idx_next;
        wr_reg       <= wr_next;
        cnt_reg      <= cnt_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        neg_reg      <= neg_next;
        rvld_reg     <= rvld_next;
        mean_res_reg <= mean_res_next;
        stat_res_reg <= stat_res_next;
        oent_reg     <= oent_next;
        omean_reg    <= omean_next;
        ostat_reg    <= ostat_next;
        olast_reg    <= olast_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        opnd_next     = opnd_reg;
        idx_next      = idx_reg;
        wr_next       = wr_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        neg_next      = neg_reg;
        rvld_next     = rvld_reg;
        mean_res_next = mean_res_reg;
        stat_res_next = stat_res_reg;
        vld_next      = vld_reg;
        ov_next       = ov_reg;
        oent_next     = oent_reg;
        omean_next    = omean_reg;
        ostat_next    = ostat_reg;
        olast_next    = olast_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = opnd_reg;
        alu_op        = ALU_ADD;
        alu_a         = acc_reg;
        alu_b         = {{(ACC_W-DATA_W){slot_val[DATA_W-1]}}, slot_val};
        cmd_ready     = 1'b0;

        // drop the output once the receiver takes it
        if (ov_reg && rsp_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    act_next      = action;
                    opnd_next     = operand_value;
                    idx_next      = '0;
                    wr_next       = '0;
                    cnt_next      = '0;
                    acc_next      = '0;
                    mean_res_next = '0;
                    stat_res_next = ST_OK;
                    // removing zero changes nothing
                    if (action == ACT_REMOVE && operand_value == '0)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_ISSUE;
                    end
                end
            end

            S_ISSUE:
            begin
                ram_re     = 1'b1;
                rvld_next  = vld_reg[idx_reg];
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                case (act_reg)
                    ACT_ADD:
                    begin
                        if (slot_val == '0)
                        begin
                            ram_we            = 1'b1;
                            vld_next[idx_reg] = 1'b1;
                            state_next        = S_OUT;
                        end
                        else if (idx_reg == LAST_IDX)
                        begin
                            stat_res_next = ST_FULL;
                            state_next    = S_OUT;
                        end
                        else
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = S_ISSUE;
                        end
                    end

                    ACT_READ:
                    begin
                        // read data holds while the receiver stalls
                        if (out_free)
                        begin
                            ov_next    = 1'b1;
                            oent_next  = slot_val;
                            omean_next = '0;
                            ostat_next = ST_OK;
                            olast_next = (idx_reg == LAST_IDX);
                            if (idx_reg == LAST_IDX)
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                idx_next   = idx_reg + 1'b1;
                                state_next = S_ISSUE;
                            end
                        end
                    end

                    ACT_AVG:
                    begin
                        if (slot_val != '0)
                        begin
                            acc_next = alu_res;
                            cnt_next = cnt_reg + 1'b1;
                        end
                        if (idx_reg == LAST_IDX)
                        begin
                            if (cnt_next == '0)
                            begin
                                stat_res_next = ST_EMPTY;
                                state_next    = S_OUT;
                            end
                            else
                            begin
                                state_next = S_ABS;
                            end
                        end
                        else
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = S_ISSUE;
                        end
                    end

                    ACT_REMOVE:
                    begin
                        // survivors move down to the write pointer
                        if (slot_val != opnd_reg)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = wr_reg[IDX_W-1:0];
                            ram_wdata  = slot_val;
                            vld_next[wr_reg[IDX_W-1:0]] = 1'b1;
                            wr_next    = wr_reg + 1'b1;
                        end
                        if (idx_reg == LAST_IDX)
                        begin
                            state_next = S_FILL;
                        end
                        else
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = S_ISSUE;
                        end
                    end

                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end

            S_FILL:
            begin
                // tail past the write pointer becomes empty
                for (int j = 0; j < SLOT_COUNT; j++)
                begin
                    if (CNT_W'(j) >= wr_reg)
                    begin
                        vld_next[j] = 1'b0;
                    end
                end
                state_next = S_OUT;
            end

            S_ABS:
            begin
                // magnitude of the sum, scaled by the fraction bits
                alu_op    = ALU_SUB;
                alu_a     = '0;
                alu_b     = acc_reg;
                neg_next  = acc_reg[ACC_W-1];
                acc_next  = (acc_reg[ACC_W-1] ? alu_res : acc_reg) << FRAC_W;
                rem_next  = '0;
                step_next = '0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                // restoring division, one quotient bit per cycle
                alu_op = ALU_SUB;
                alu_a  = ACC_W'(rem_sh);
                alu_b  = ACC_W'(cnt_reg);
                if (alu_res[ACC_W-1])
                begin
                    rem_next = rem_sh[CNT_W-1:0];
                    acc_next = {acc_reg[ACC_W-2:0], 1'b0};
                end
                else
                begin
                    rem_next = alu_res[CNT_W-1:0];
                    acc_next = {acc_reg[ACC_W-2:0], 1'b1};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_NEG;
                end
            end

            S_NEG:
            begin
                alu_op        = ALU_SUB;
                alu_a         = '0;
                alu_b         = acc_reg;
                mean_res_next = neg_reg ? alu_res[MEAN_W-1:0] : acc_reg[MEAN_W-1:0];
                state_next    = S_OUT;
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    oent_next  = '0;
                    omean_next = mean_res_reg;
                    ostat_next = stat_res_reg;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid   = ov_reg;
    assign entry_value = oent_reg;
    assign mean_q8     = omean_reg;
    assign status      = ostat_reg;
    assign last        = olast_reg;

endmodule

/* verif/tb.sv */
// tb: self-checking testbench for compacting_list_table_unit
// keeps a shadow copy of the slot table and predicts every result of each command
// depends on clt_pkg and the compacting_list_table_unit rtl
`timescale 1ns / 1ps

module tb;
    import clt_pkg::*;

    localparam int NSLOT = 10;
    localparam int LIMIT = 200000;     // cycles, far above the slowest correct run
    localparam int DRAIN = 80;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh80000000;

    // one result item as seen on the rsp channel
    typedef struct packed {
        logic signed [DATA_W-1:0] entry;
        logic signed [MEAN_W-1:0] mean;
        logic [1:0]               status;
        logic                     last;
    } table_rsp_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cmd_valid;
    logic                     cmd_ready;
    logic [1:0]               action;
    logic signed [DATA_W-1:0] operand_value;
    logic                     rsp_valid;
    logic                     rsp_ready;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [MEAN_W-1:0] mean_q8;
    logic [1:0]               status;
    logic                     last;

    // shadow of the slot table, zero means empty
    logic signed [DATA_W-1:0] shadow_slots [NSLOT];
    // results still owed by the block, oldest first
    table_rsp_t               owed_rsp [$];

    int  fault_count = 0;
    int  cycle_count = 0;
    bit  calm = 1'b0;                  // when set neither side idles

    compacting_list_table_unit #(
        .SLOT_COUNT(NSLOT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .action       (action),
        .operand_value(operand_value),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .entry_value  (entry_value),
        .mean_q8      (mean_q8),
        .status       (status),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, owed_rsp.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stalls at random, about 30 percent of the time, unless calm
    always @(posedge clk)
        rsp_ready <= calm || ($urandom_range(0, 99) >= 30);

    // number of idle cycles before the next command
    function automatic int idle_gap();
        int n;
        n = 0;
        while (n < 12 && $urandom_range(0, 99) < 30)
            n++;
        return n;
    endfunction

    function automatic table_rsp_t make_rsp(logic signed [DATA_W-1:0] entry,
                                            logic signed [MEAN_W-1:0] mean,
                                            logic [1:0] st, logic lst);
        table_rsp_t r;
        r.entry  = entry;
        r.mean   = mean;
        r.status = st;
        r.last   = lst;
        return r;
    endfunction

    // update the shadow table for one accepted command and queue its results
    function automatic void predict_command(logic [1:0] act, logic signed [DATA_W-1:0] val);
        bit     placed;
        int     w;
        longint total;
        longint used;
        longint mag;
        longint quot;
        logic signed [MEAN_W-1:0] mean;
        case (act)
            ACT_ADD:
            begin
                // first empty slot takes the value; adding zero leaves it empty
                placed = 1'b0;
                for (int i = 0; i < NSLOT && !placed; i++)
                    if (shadow_slots[i] == 0)
                    begin
                        shadow_slots[i] = val;
                        placed = 1'b1;
                    end
                owed_rsp.push_back(make_rsp('0, '0, placed ? ST_OK : ST_FULL, 1'b1));
            end
            ACT_READ:
                for (int i = 0; i < NSLOT; i++)
                    owed_rsp.push_back(make_rsp(shadow_slots[i], '0, ST_OK, i == NSLOT - 1));
            ACT_AVG:
            begin
                total = 0;
                used  = 0;
                foreach (shadow_slots[i])
                    if (shadow_slots[i] != 0)
                    begin
                        total += longint'(shadow_slots[i]);
                        used++;
                    end
                if (used == 0)
                    owed_rsp.push_back(make_rsp('0, '0, ST_EMPTY, 1'b1));
                else
                begin
                    // divide the magnitude so the quotient truncates toward zero
                    mag  = (total < 0) ? -total : total;
                    quot = (mag * 256) / used;
                    mean = MEAN_W'((total < 0) ? -quot : quot);
                    owed_rsp.push_back(make_rsp('0, mean, ST_OK, 1'b1));
                end
            end
            default:
            begin
                // remove: removing zero does nothing
                if (val != 0)
                begin
                    w = 0;
                    for (int i = 0; i < NSLOT; i++)
                        if (shadow_slots[i] != val)
                        begin
                            shadow_slots[w] = shadow_slots[i];
                            w++;
                        end
                    for (; w < NSLOT; w++)
                        shadow_slots[w] = '0;
                end
                owed_rsp.push_back(make_rsp('0, '0, ST_OK, 1'b1));
            end
        endcase
    endfunction

    function automatic void log_fault(string what, table_rsp_t want, table_rsp_t got);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch at cycle %0d (%s): expected entry=%0d mean=%0d status=%0d",
                     cycle_count, what, want.entry, want.mean, want.status,
                     " last=%0d, got entry=%0d mean=%0d status=%0d last=%0d",
                     want.last, got.entry, got.mean, got.status, got.last);
    endfunction

    // result checker: every rsp transfer against the oldest owed result
    always @(posedge clk)
    begin
        table_rsp_t got;
        table_rsp_t want;
        string      bad;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            got = make_rsp(entry_value, mean_q8, status, last);
            if (owed_rsp.size() == 0)
                log_fault("no result expected", '0, got);
            else
            begin
                want = owed_rsp.pop_front();
                bad  = "";
                if (got.entry !== want.entry)
                    bad = {bad, " entry_value"};
                if (got.mean !== want.mean)
                    bad = {bad, " mean_q8"};
                if (got.status !== want.status)
                    bad = {bad, " status"};
                if (got.last !== want.last)
                    bad = {bad, " last"};
                if (bad != "")
                    log_fault({"field", bad}, want, got);
            end
        end
    end

    // one command transfer; valid stays up after the transfer so a back-to-back
    // command needs only one assignment in that time step
    task automatic send_cmd(input logic [1:0] act, input logic signed [DATA_W-1:0] val);
        int gap;
        gap = calm ? 0 : idle_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid     <= 1'b1;
        action        <= act;
        operand_value <= val;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        predict_command(act, val);
    endtask

    // empty table: read, average reports empty, removing zero is a no-op
    task automatic test_empty_table();
        send_cmd(ACT_READ, 32'sd0);
        send_cmd(ACT_AVG, WORD_MAX);
        send_cmd(ACT_REMOVE, 32'sd0);
    endtask

    // word extremes, adding zero, removing an absent value, mean of mixed signs
    task automatic test_extremes();
        send_cmd(ACT_ADD, WORD_MAX);
        send_cmd(ACT_ADD, WORD_MIN);
        send_cmd(ACT_ADD, 32'sd0);
        send_cmd(ACT_AVG, 32'sd0);
        send_cmd(ACT_REMOVE, 32'sd5);
        send_cmd(ACT_REMOVE, WORD_MIN);
        send_cmd(ACT_READ, WORD_MIN);
        send_cmd(ACT_REMOVE, WORD_MAX);
    endtask

    // fill every slot, add to a full table, mean at the negative extreme,
    // then one remove clears all duplicates
    task automatic test_full_table();
        for (int i = 0; i < NSLOT; i++)
            send_cmd(ACT_ADD, WORD_MIN);
        send_cmd(ACT_ADD, 32'sd7);
        send_cmd(ACT_ADD, 32'sd0);
        send_cmd(ACT_AVG, 32'sd0);
        send_cmd(ACT_REMOVE, WORD_MIN);
    endtask

    // operand picked to hit duplicates, table contents and extremes
    function automatic logic signed [DATA_W-1:0] pick_operand(bit prefer_present);
        logic signed [DATA_W-1:0] v;
        int idx;
        if (prefer_present && $urandom_range(0, 99) < 60)
        begin
            idx = $urandom_range(0, NSLOT - 1);
            if (shadow_slots[idx] != 0)
                return shadow_slots[idx];
        end
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = ($urandom_range(0, 1) != 0) ? WORD_MAX : WORD_MIN;
            2, 3, 4: v = $urandom;
            default:
            begin
                v = $urandom_range(1, 6);
                if ($urandom_range(0, 1) != 0)
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // random mix weighted toward add so the table keeps filling up;
    // a stretch in the middle runs with no idling on either side
    task automatic test_random_mix(input int count);
        int pick;
        logic [1:0] act;
        for (int n = 0; n < count; n++)
        begin
            calm = (n >= 40 && n < 70);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                act = ACT_ADD;
            else if (pick < 60)
                act = ACT_REMOVE;
            else if (pick < 80)
                act = ACT_AVG;
            else
                act = ACT_READ;
            send_cmd(act, pick_operand(act == ACT_REMOVE));
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        action        = ACT_ADD;
        operand_value = '0;
        foreach (shadow_slots[i])
            shadow_slots[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_extremes();
        test_full_table();
        test_random_mix(75);

        // last command was just taken: drop valid in this same step
        cmd_valid <= 1'b0;
        while (owed_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
rtl/clt_pkg.sv
rtl/clt_ram.sv
rtl/clt_alu.sv
rtl/compacting_list_table_unit.sv
verif/tb.sv
